// ===== design/sbwc_pkg.sv =====
`default_nettype none
package sbwc_pkg;

  localparam int BLOCK_BYTES   = 256;
  localparam int DEVICE_BLOCKS = 512;
  localparam int WORD_BYTES    = 8;

  localparam int WORDS      = BLOCK_BYTES / WORD_BYTES;
  localparam int IDX_W      = $clog2(WORDS);
  localparam int OFF_W      = $clog2(BLOCK_BYTES);
  localparam int LANE_W     = $clog2(WORD_BYTES);
  localparam int WORD_W     = WORD_BYTES * 8;

  localparam int OP_W       = 3;
  localparam int ADDR_W     = 17;
  localparam int VAL_W      = 8;
  localparam int FILL_W     = 64;
  localparam int KIND_W     = 3;
  localparam int BLK_NUM_W  = 9;
  localparam int IDX_OUT_W  = 5;
  localparam int LIM_W      = 10;
  localparam int CFG_BLK_W  = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int BLK_W      = ADDR_W - OFF_W;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 88;

  localparam logic [LIM_W-1:0]     LIMIT_RESET   = LIM_W'(511);
  localparam logic [CFG_BLK_W-1:0] CFG_BLK_RESET = CFG_BLK_W'(511);

  localparam logic [CFG_IDX_W-1:0] REG_DATA_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIG_BLOCK = 1'b1;

  localparam logic [OP_W-1:0] OP_DATA_RD = 3'd0;
  localparam logic [OP_W-1:0] OP_DATA_WR = 3'd1;
  localparam logic [OP_W-1:0] OP_CFG_RD  = 3'd2;
  localparam logic [OP_W-1:0] OP_CFG_WR  = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH   = 3'd4;
  localparam logic [OP_W-1:0] OP_FILL    = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    K_READ_DATA  = 3'd0,
    K_WRITE_DONE = 3'd1,
    K_WB_WORD    = 3'd2,
    K_FILL_REQ   = 3'd3,
    K_RANGE_ERR  = 3'd4,
    K_FLUSH_DONE = 3'd5,
    K_BUSY       = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_WB,
    ST_FILL_REQ,
    ST_FINISH,
    ST_READ_OUT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  val;
    logic              whole;
    logic [FILL_W-1:0] fill;
  } item_t;

  typedef struct packed {
    kind_e                kind;
    logic [BLK_NUM_W-1:0] blk;
    logic [IDX_OUT_W-1:0] idx;
    logic [WORD_W-1:0]    data;
    logic [VAL_W-1:0]     rv;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [WORD_BYTES-1:0] wr_be;
    logic [WORD_W-1:0]     wr_data;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== design/sbwc_buffer.sv =====
`default_nettype none
module sbwc_buffer
  import sbwc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire mem_req_t          req_i,
  output logic     [WORD_W-1:0]  rd_data_o
);

  // block buffer as words with byte lanes; contents undefined until written
  logic [WORD_W-1:0] mem [WORDS];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      for (int l = 0; l < WORD_BYTES; l++) begin
        if (req_i.wr_be[l]) begin
          mem[req_i.wr_idx][l*8 +: 8] <= req_i.wr_data[l*8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem[req_i.rd_idx];
    end
  end

endmodule
`default_nettype wire

// ===== design/sbwc_out_reg.sv =====
`default_nettype none
module sbwc_out_reg
  import sbwc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire res_t res_i,
  input  wire logic tready_i,
  output logic      tvalid_o,
  output res_t      res_o,
  output logic      free_o
);

  logic valid_d, valid_q;
  res_t res_q;

  assign free_o   = !valid_q || tready_i;
  assign tvalid_o = valid_q;
  assign res_o    = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/sbwc_ctrl.sv =====
`default_nettype none
module sbwc_ctrl
  import sbwc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire item_t                item_i,
  output logic                      in_ready_o,
  input  wire logic [LIM_W-1:0]     data_limit_i,
  input  wire logic [CFG_BLK_W-1:0] cfg_blk_i,
  output mem_req_t                  mem_req_o,
  input  wire logic [WORD_W-1:0]    rd_data_i,
  input  wire logic                 out_free_i,
  output logic                      out_load_o,
  output res_t                      res_o
);

  state_e state_d, state_q;
  state_e wb_next_d, wb_next_q;
  state_e after_st;
  kind_e  resp_kind_d, resp_kind_q;

  logic [BLK_W-1:0] tag_blk_d, tag_blk_q;
  logic             tag_valid_d, tag_valid_q;
  logic             dirty_d, dirty_q;
  logic             fill_pend_d, fill_pend_q;
  logic [IDX_W-1:0] fill_cnt_d, fill_cnt_q;
  logic [1:0]       pend_acc_d, pend_acc_q;
  logic [OFF_W-1:0] pend_off_d, pend_off_q;
  logic [VAL_W-1:0] pend_val_d, pend_val_q;
  logic [IDX_W-1:0] wb_idx_d, wb_idx_q;
  logic [BLK_W-1:0] wb_blk_d, wb_blk_q;

  logic             is_data;
  logic [BLK_W-1:0] data_blk;
  logic [BLK_W-1:0] acc_blk;
  logic [LIM_W-1:0] lim_sat;
  logic             range_bad;
  logic             wb_start;

  assign is_data   = (item_i.op == OP_DATA_RD) || (item_i.op == OP_DATA_WR);
  assign data_blk  = item_i.addr[ADDR_W-1:OFF_W];
  assign acc_blk   = is_data ? data_blk : BLK_W'(cfg_blk_i % DEVICE_BLOCKS);
  assign lim_sat   = (data_limit_i > LIM_W'(DEVICE_BLOCKS)) ? LIM_W'(DEVICE_BLOCKS)
                                                            : data_limit_i;
  assign range_bad = LIM_W'(data_blk) >= lim_sat;

  always_comb begin
    state_d     = state_q;
    wb_next_d   = wb_next_q;
    resp_kind_d = resp_kind_q;
    tag_blk_d   = tag_blk_q;
    tag_valid_d = tag_valid_q;
    dirty_d     = dirty_q;
    fill_pend_d = fill_pend_q;
    fill_cnt_d  = fill_cnt_q;
    pend_acc_d  = pend_acc_q;
    pend_off_d  = pend_off_q;
    pend_val_d  = pend_val_q;
    wb_idx_d    = wb_idx_q;
    wb_blk_d    = wb_blk_q;
    after_st    = ST_FILL_REQ;
    wb_start    = 1'b0;
    mem_req_o   = '0;
    out_load_o  = 1'b0;
    res_o       = '0;
    in_ready_o  = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (item_i.op == OP_FILL) begin
            // fill words with no fill pending are dropped
            if (fill_pend_q) begin
              mem_req_o.wr_en   = 1'b1;
              mem_req_o.wr_idx  = fill_cnt_q;
              mem_req_o.wr_be   = '1;
              mem_req_o.wr_data = WORD_W'(item_i.fill);
              if (fill_cnt_q == IDX_W'(WORDS - 1)) begin
                fill_pend_d = 1'b0;
                tag_valid_d = 1'b1;
                fill_cnt_d  = '0;
                state_d     = ST_FINISH;
              end else begin
                fill_cnt_d = fill_cnt_q + 1'b1;
              end
            end
          end else if (item_i.op inside {OP_DATA_RD, OP_DATA_WR, OP_CFG_RD, OP_CFG_WR,
                                         OP_FLUSH}) begin
            if (fill_pend_q) begin
              resp_kind_d = K_BUSY;
              state_d     = ST_RESP;
            end else if (item_i.op == OP_FLUSH) begin
              resp_kind_d = K_FLUSH_DONE;
              after_st    = ST_RESP;
              wb_start    = tag_valid_q && dirty_q;
              state_d     = ST_RESP;
            end else if (is_data && range_bad) begin
              resp_kind_d = K_RANGE_ERR;
              state_d     = ST_RESP;
            end else begin
              pend_acc_d = item_i.op[1:0];
              pend_off_d = item_i.addr[OFF_W-1:0];
              pend_val_d = item_i.val;
              if (tag_valid_q && tag_blk_q == acc_blk) begin
                state_d = ST_FINISH;
              end else begin
                tag_blk_d = acc_blk;
                if (item_i.op == OP_DATA_WR && item_i.whole) begin
                  tag_valid_d = 1'b1;
                  after_st    = ST_FINISH;
                end else begin
                  tag_valid_d = 1'b0;
                  fill_pend_d = 1'b1;
                  fill_cnt_d  = '0;
                  after_st    = ST_FILL_REQ;
                end
                wb_start = tag_valid_q && dirty_q;
                state_d  = after_st;
              end
            end
            // dirty victim: read word 0 now, the outgoing tag is latched for the words
            if (wb_start) begin
              mem_req_o.rd_en  = 1'b1;
              mem_req_o.rd_idx = '0;
              wb_idx_d         = '0;
              wb_blk_d         = tag_blk_q;
              wb_next_d        = after_st;
              state_d          = ST_WB;
            end
          end
        end
      end

      ST_RESP: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          res_o.kind = resp_kind_q;
          res_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_WB: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          res_o.kind = K_WB_WORD;
          res_o.blk  = BLK_NUM_W'(wb_blk_q);
          res_o.idx  = IDX_OUT_W'(wb_idx_q);
          res_o.data = rd_data_i;
          if (wb_idx_q == IDX_W'(WORDS - 1)) begin
            dirty_d = 1'b0;
            state_d = wb_next_q;
          end else begin
            mem_req_o.rd_en  = 1'b1;
            mem_req_o.rd_idx = wb_idx_q + 1'b1;
            wb_idx_d         = wb_idx_q + 1'b1;
          end
        end
      end

      ST_FILL_REQ: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          res_o.kind = K_FILL_REQ;
          res_o.blk  = BLK_NUM_W'(tag_blk_q);
          res_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_FINISH: begin
        if (pend_acc_q[0]) begin
          if (out_free_i) begin
            mem_req_o.wr_en   = 1'b1;
            mem_req_o.wr_idx  = pend_off_q[OFF_W-1:LANE_W];
            mem_req_o.wr_be   = WORD_BYTES'(1) << pend_off_q[LANE_W-1:0];
            mem_req_o.wr_data = {WORD_BYTES{pend_val_q}};
            dirty_d           = 1'b1;
            out_load_o        = 1'b1;
            res_o.kind        = K_WRITE_DONE;
            res_o.last        = 1'b1;
            state_d           = ST_IDLE;
          end
        end else begin
          mem_req_o.rd_en  = 1'b1;
          mem_req_o.rd_idx = pend_off_q[OFF_W-1:LANE_W];
          state_d          = ST_READ_OUT;
        end
      end

      ST_READ_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          res_o.kind = K_READ_DATA;
          res_o.rv   = rd_data_i[pend_off_q[LANE_W-1:0]*8 +: 8];
          res_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_blk_q   <= '0;
      tag_valid_q <= 1'b0;
      dirty_q     <= 1'b0;
      fill_pend_q <= 1'b0;
      fill_cnt_q  <= '0;
      wb_idx_q    <= '0;
      wb_next_q   <= ST_IDLE;
    end else begin
      tag_blk_q   <= tag_blk_d;
      tag_valid_q <= tag_valid_d;
      dirty_q     <= dirty_d;
      fill_pend_q <= fill_pend_d;
      fill_cnt_q  <= fill_cnt_d;
      wb_idx_q    <= wb_idx_d;
      wb_next_q   <= wb_next_d;
    end
  end

  always_ff @(posedge clk_i) begin
    resp_kind_q <= resp_kind_d;
    pend_acc_q  <= pend_acc_d;
    pend_off_q  <= pend_off_d;
    pend_val_q  <= pend_val_d;
    wb_blk_q    <= wb_blk_d;
  end

`ifndef NO_ASSERTIONS
  a_fill_no_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_pend_q |-> !tag_valid_q)
    else $error("fill pending while a block is marked valid");

  a_cnt_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_cnt_q != '0) |-> fill_pend_q)
    else $error("fill counter advanced without a pending fill");

  a_idle_dirty_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && dirty_q) |-> tag_valid_q)
    else $error("dirty buffer without a valid tag");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load_o && res_o.last) |=> (state_q == ST_IDLE))
    else $error("final result issued but control not back to idle");
`endif

endmodule
`default_nettype wire

// ===== design/single_block_writeback_cache_unit.sv =====
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/s_axis_tready tuser: opcode; tdata: addr, value, whole, fill
// m_axis    out  m_axis_tvalid/m_axis_tready tuser: kind; tdata: blk, idx, word, byte; tlast
// cfg       in   cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// One item at a time. A fill word that is not the last, a stray fill word or an ignored
// opcode gives no result; busy, range error, clean flush, clean miss, hit and whole-block
// writes give one result, hit reads after the registered buffer read. The last fill
// word ends the access. A dirty victim adds 32 writeback words, one per cycle unless stalled.
// Results pass through a one-deep output register; m_axis_tready low stalls the sequencer.
// Reset (rst_ni, async low) clears tag, valid, dirty and fill state; buffer is not cleared.
`default_nettype none
module single_block_writeback_cache_unit
  import sbwc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [16:0] byte_address, [24:17] write_value, [25] whole_block, [89:26] fill_data
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] opcode
  input  wire logic [OP_W-1:0]        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [8:0] block_number, [13:9] word_index, [77:14] word_data, [85:78] read_value
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // [2:0] kind
  output logic [KIND_W-1:0]           m_axis_tuser,
  output logic                        m_axis_tlast,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic [LIM_W-1:0]     data_limit_q;
  logic [CFG_BLK_W-1:0] cfg_blk_q;

  item_t             item;
  mem_req_t          mem_req;
  logic [WORD_W-1:0] rd_data;
  logic              out_free;
  logic              out_load;
  res_t              res_in;
  res_t              res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_limit_q <= LIMIT_RESET;
      cfg_blk_q    <= CFG_BLK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DATA_LIMIT:   data_limit_q <= cfg_wdata_i[LIM_W-1:0];
        REG_CONFIG_BLOCK: cfg_blk_q    <= cfg_wdata_i[CFG_BLK_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.op    = s_axis_tuser;
  assign item.addr  = s_axis_tdata[ADDR_W-1:0];
  assign item.val   = s_axis_tdata[ADDR_W +: VAL_W];
  assign item.whole = s_axis_tdata[ADDR_W + VAL_W];
  assign item.fill  = s_axis_tdata[ADDR_W + VAL_W + 1 +: FILL_W];

  sbwc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .item_i       (item),
    .in_ready_o   (s_axis_tready),
    .data_limit_i (data_limit_q),
    .cfg_blk_i    (cfg_blk_q),
    .mem_req_o    (mem_req),
    .rd_data_i    (rd_data),
    .out_free_i   (out_free),
    .out_load_o   (out_load),
    .res_o        (res_in)
  );

  sbwc_buffer u_buffer (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  sbwc_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (out_load),
    .res_i    (res_in),
    .tready_i (m_axis_tready),
    .tvalid_o (m_axis_tvalid),
    .res_o    (res_out),
    .free_o   (out_free)
  );

  assign m_axis_tdata = {2'b00, res_out.rv, res_out.data, res_out.idx, res_out.blk};
  assign m_axis_tuser = res_out.kind;
  assign m_axis_tlast = res_out.last;

endmodule
`default_nettype wire
